### src/bct_pkg.sv
// ----------------------------------------------------------------------------
// bct_pkg
// Shared constants, codes and controller/datapath interface types for the
// beat clock tracker.
// ----------------------------------------------------------------------------
package bct_pkg;

  // Saturation range of the time values is [-2^TIME_BITS, 2^TIME_BITS-1]
  localparam int TIME_BITS = 48;
  localparam int TW        = 49;   // time field width
  localparam int BW        = 40;   // beat field width
  localparam int TEMPO_W   = 24;
  localparam int A_W       = 56;   // multiplicand width
  localparam int M_W       = 24;   // multiplier width
  localparam int D_W       = 40;   // divisor width
  localparam int P_W       = A_W + M_W;
  localparam int ND_W      = 89;   // dividend / quotient width
  localparam int SUM_W     = 66;

  localparam logic [M_W-1:0]     MS_PER_MIN_Q8 = 24'd15360000;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET   = 24'd30720;
  localparam logic [BW-1:0]      BEAT_MAX      = {BW{1'b1}};
  localparam logic [16:0]        PHASE_ONE     = 17'd65536;

  localparam logic signed [SUM_W-1:0] T_MAX =
    (66'sd1 <<< TIME_BITS) - 66'sd1;
  localparam logic signed [SUM_W-1:0] T_MIN = -T_MAX - 66'sd1;

  // Request codes; other codes act as a query
  localparam logic [2:0] REQ_QUERY     = 3'd0;
  localparam logic [2:0] REQ_SET_TEMPO = 3'd1;
  localparam logic [2:0] REQ_SET_PHASE = 3'd2;
  localparam logic [2:0] REQ_JUMP      = 3'd3;
  localparam logic [2:0] REQ_SHIFT     = 3'd4;
  localparam logic [2:0] REQ_BEAT_TIME = 3'd5;

  typedef enum logic [2:0] {
    MD_SNAP,
    MD_TEMPO,
    MD_PHASE,
    MD_JUMP,
    MD_BTIME
  } md_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SNAP0_W,
    ST_OP_START,
    ST_OP_W,
    ST_APPLY,
    ST_SNAP1,
    ST_SNAP1_W,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic    capture;
    logic    md_start;
    md_sel_t md_sel;
    logic    snap_latch;
    logic    apply;
    logic    load_out;
  } bct_cmd_t;

  typedef struct packed {
    logic       md_done;
    logic [2:0] kind;
    logic       tempo_zero;
    logic       out_free;
  } bct_stat_t;

endpackage

### src/bct_muldiv.sv
// ----------------------------------------------------------------------------
// bct_muldiv
// Sequential floor(a * m / d): shift-add multiply over the multiplier bits,
// then restoring division one quotient bit per cycle. With sh16 set the
// product is scaled by 2^16 so the low quotient bits give the fraction.
// ----------------------------------------------------------------------------
module bct_muldiv (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [bct_pkg::A_W-1:0]    a,
  input  logic [bct_pkg::M_W-1:0]    m,
  input  logic [bct_pkg::D_W-1:0]    d,
  input  logic                       sh16,
  output logic                       done,
  output logic [bct_pkg::ND_W-1:0]   q
);
  import bct_pkg::*;

  localparam int CNT_W = $clog2(ND_W);

  logic             busy;
  logic             mul_ph;
  logic [CNT_W-1:0] cnt;
  logic [A_W-1:0]   a_r;
  logic [M_W-1:0]   m_r;
  logic [D_W-1:0]   d_r;
  logic             sh_r;
  logic [P_W-1:0]   acc;
  logic [P_W-1:0]   acc_next;
  logic [ND_W-1:0]  nd;
  logic [D_W-1:0]   rem;
  logic [D_W:0]     rem_sh;
  logic [D_W:0]     rem_sub;
  logic             ge;

  always_comb begin
    acc_next = {acc[P_W-2:0], 1'b0} + (m_r[M_W-1] ? {{M_W{1'b0}}, a_r} : '0);
    rem_sh   = {rem, nd[ND_W-1]};
    rem_sub  = rem_sh - {1'b0, d_r};
    ge       = (rem_sh >= {1'b0, d_r});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      mul_ph <= 1'b0;
      done   <= 1'b0;
      cnt    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy   <= 1'b1;
        mul_ph <= 1'b1;
        cnt    <= CNT_W'(M_W - 1);
      end else if (busy && mul_ph) begin
        if (cnt == '0) begin
          mul_ph <= 1'b0;
          cnt    <= CNT_W'(ND_W - 1);
        end else begin
          cnt <= cnt - 1'b1;
        end
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r  <= a;
      m_r  <= m;
      d_r  <= d;
      sh_r <= sh16;
      acc  <= '0;
    end else if (busy && mul_ph) begin
      acc <= acc_next;
      m_r <= {m_r[M_W-2:0], 1'b0};
      if (cnt == '0) begin
        rem <= '0;
        // scaled product stays below 2^73 when sh16 is used
        nd  <= sh_r ? {acc_next[ND_W-17:0], 16'b0}
                    : {{(ND_W-P_W){1'b0}}, acc_next};
      end
    end else if (busy) begin
      rem <= ge ? rem_sub[D_W-1:0] : rem_sh[D_W-1:0];
      nd  <= {nd[ND_W-2:0], ge};
    end
  end

  assign q = nd;

endmodule

### src/bct_datapath.sv
// ----------------------------------------------------------------------------
// bct_datapath
// Grid state, captured request, operand selection for the shared mul/div
// unit, state updates and the output register.
// ----------------------------------------------------------------------------
module bct_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  bct_pkg::bct_cmd_t               cmd,
  output bct_pkg::bct_stat_t              stat,
  input  logic [2:0]                      req_type,
  input  logic [46:0]                     now_ms,
  input  logic [23:0]                     tempo_value,
  input  logic [16:0]                     phase_value,
  input  logic signed [39:0]              beat_number,
  input  logic signed [31:0]              shift_ms,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [39:0]                     beat_count,
  output logic [15:0]                     phase_frac,
  output logic signed [48:0]              grid_start_ms,
  output logic [23:0]                     tempo_now,
  output logic signed [48:0]              beat_time_ms,
  output logic                            ignored
);
  import bct_pkg::*;

  // grid state
  logic signed [TW-1:0]  start_time;
  logic [TEMPO_W-1:0]    tempo_reg;

  // captured request
  logic [2:0]            kind_r;
  logic [46:0]           now_r;
  logic [TEMPO_W-1:0]    tval_r;
  logic [16:0]           pval_r;
  logic signed [39:0]    bnum_r;
  logic signed [31:0]    delta_r;

  // working results
  logic [BW-1:0]         beat;
  logic [15:0]           phase;
  logic signed [TW-1:0]  btime;
  logic                  ign;

  // mul/div operands
  logic [A_W-1:0]        md_a;
  logic [M_W-1:0]        md_m;
  logic [D_W-1:0]        md_d;
  logic                  md_sh;
  logic                  md_done;
  logic [ND_W-1:0]       md_q;

  logic signed [49:0]    dsn;
  logic [BW-1:0]         beat_m1;
  logic                  bnum_low;
  logic [BW-1:0]         jump_a;
  logic signed [40:0]    bnum_x;
  logic [40:0]           mag;
  logic [16:0]           pclamp;
  logic [63:0]           off;
  logic [ND_W-17:0]      qi;

  logic signed [SUM_W-1:0] sub_s;
  logic signed [TW-1:0]    sub_res;
  logic signed [SUM_W-1:0] add_b;
  logic signed [SUM_W-1:0] add_s;
  logic signed [TW-1:0]    add_res;

  always_comb begin
    dsn      = $signed({3'b0, now_r}) - $signed({start_time[TW-1], start_time});
    beat_m1  = beat - 1'b1;
    bnum_low = bnum_r[39] || (bnum_r == '0);
    jump_a   = bnum_low ? '0 : 40'(bnum_r - 40'sd1);
    bnum_x   = {bnum_r[39], bnum_r};
    mag      = bnum_low ? 41'(41'sd1 - bnum_x) : 41'(bnum_x - 41'sd1);
    pclamp   = (pval_r > PHASE_ONE) ? PHASE_ONE : pval_r;

    md_a  = '0;
    md_m  = MS_PER_MIN_Q8;
    md_d  = {{(D_W-TEMPO_W){1'b0}}, tempo_reg};
    md_sh = 1'b0;
    unique case (cmd.md_sel)
      MD_SNAP: begin
        // before the grid start the beat is 1 with phase 0
        md_a  = dsn[49] ? '0 : {{(A_W-TW){1'b0}}, dsn[TW-1:0]};
        md_m  = tempo_reg;
        md_d  = {{(D_W-M_W){1'b0}}, MS_PER_MIN_Q8};
        md_sh = 1'b1;
      end
      MD_TEMPO: begin
        md_a = {{(A_W-BW){1'b0}}, beat_m1};
        md_d = {{(D_W-TEMPO_W){1'b0}}, tval_r};
      end
      MD_PHASE: begin
        md_a = {beat_m1, 16'b0} + {{(A_W-17){1'b0}}, pclamp};
        md_d = {tempo_reg, 16'b0};
      end
      MD_JUMP:  md_a = {{(A_W-BW){1'b0}}, jump_a};
      MD_BTIME: md_a = {{(A_W-41){1'b0}}, mag};
      default:  md_a = '0;
    endcase
  end

  bct_muldiv u_muldiv (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.md_start),
    .a     (md_a),
    .m     (md_m),
    .d     (md_d),
    .sh16  (md_sh),
    .done  (md_done),
    .q     (md_q)
  );

  always_comb begin
    off = md_q[63:0];
    qi  = md_q[ND_W-1:16];

    // now - off, saturating at the low end
    sub_s = $signed({19'b0, now_r}) - $signed({2'b0, off});
    sub_res = (sub_s < T_MIN) ? T_MIN[TW-1:0] : sub_s[TW-1:0];

    if (kind_r == REQ_SHIFT) begin
      add_b = {{(SUM_W-32){delta_r[31]}}, delta_r};
    end else if (bnum_low) begin
      add_b = -$signed({2'b0, off});
    end else begin
      add_b = $signed({2'b0, off});
    end
    add_s = {{(SUM_W-TW){start_time[TW-1]}}, start_time} + add_b;
    if (add_s > T_MAX) begin
      add_res = T_MAX[TW-1:0];
    end else if (add_s < T_MIN) begin
      add_res = T_MIN[TW-1:0];
    end else begin
      add_res = add_s[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      tempo_reg  <= TEMPO_RESET;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.apply) begin
        case (kind_r) inside
          REQ_SET_TEMPO: begin
            if (tval_r != '0) begin
              tempo_reg  <= tval_r;
              start_time <= sub_res;
            end
          end
          REQ_SET_PHASE, REQ_JUMP: start_time <= sub_res;
          REQ_SHIFT:               start_time <= add_res;
          default: ;
        endcase
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r  <= req_type;
      now_r   <= now_ms;
      tval_r  <= tempo_value;
      pval_r  <= phase_value;
      bnum_r  <= beat_number;
      delta_r <= shift_ms;
      btime   <= '0;
      ign     <= 1'b0;
    end
    if (cmd.apply) begin
      if (kind_r == REQ_BEAT_TIME) begin
        btime <= add_res;
      end
      if (kind_r == REQ_SET_TEMPO && tval_r == '0) begin
        ign <= 1'b1;
      end
    end
    if (cmd.snap_latch) begin
      if (qi >= (ND_W-16)'(BEAT_MAX - 1'b1)) begin
        beat  <= BEAT_MAX;
        phase <= '0;
      end else begin
        beat  <= qi[BW-1:0] + 1'b1;
        phase <= md_q[15:0];
      end
    end
    if (cmd.load_out) begin
      beat_count    <= beat;
      phase_frac    <= phase;
      grid_start_ms <= start_time;
      tempo_now     <= tempo_reg;
      beat_time_ms  <= btime;
      ignored       <= ign;
    end
  end

  assign stat.md_done    = md_done;
  assign stat.kind       = kind_r;
  assign stat.tempo_zero = (tval_r == '0);
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### src/bct_ctrl.sv
// ----------------------------------------------------------------------------
// bct_ctrl
// Request sequencer: orders the snapshot and offset computations on the
// shared mul/div unit and hands the result to the output register.
// ----------------------------------------------------------------------------
module bct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  bct_pkg::bct_stat_t  stat,
  output bct_pkg::bct_cmd_t   cmd
);
  import bct_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.md_sel = MD_SNAP;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if ((stat.kind == REQ_SET_TEMPO && !stat.tempo_zero) ||
            stat.kind == REQ_SET_PHASE) begin
          // these re-anchor around the beat in force before the change
          cmd.md_start = 1'b1;
          cmd.md_sel   = MD_SNAP;
          state_next   = ST_SNAP0_W;
        end else if (stat.kind == REQ_JUMP) begin
          cmd.md_start = 1'b1;
          cmd.md_sel   = MD_JUMP;
          state_next   = ST_OP_W;
        end else if (stat.kind == REQ_BEAT_TIME) begin
          cmd.md_start = 1'b1;
          cmd.md_sel   = MD_BTIME;
          state_next   = ST_OP_W;
        end else begin
          state_next = ST_APPLY;
        end
      end
      ST_SNAP0_W: begin
        if (stat.md_done) begin
          cmd.snap_latch = 1'b1;
          state_next     = ST_OP_START;
        end
      end
      ST_OP_START: begin
        cmd.md_start = 1'b1;
        cmd.md_sel   = (stat.kind == REQ_SET_TEMPO) ? MD_TEMPO : MD_PHASE;
        state_next   = ST_OP_W;
      end
      ST_OP_W: begin
        if (stat.md_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_SNAP1;
      end
      ST_SNAP1: begin
        cmd.md_start = 1'b1;
        cmd.md_sel   = MD_SNAP;
        state_next   = ST_SNAP1_W;
      end
      ST_SNAP1_W: begin
        if (stat.md_done) begin
          cmd.snap_latch = 1'b1;
          state_next     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

### src/beat_clock_tracker.sv
// ----------------------------------------------------------------------------
// beat_clock_tracker
// Beat grid tracker: keeps the start time of beat 1 and a tempo, and answers
// one result beat per request beat.
//
// Input channel (in_valid/in_ready) takes a request: kind, current time and
// the arguments of the kind. Output channel (out_valid/out_ready) gives the
// beat and phase at that time, grid start, tempo, asked beat time, ignored.
// Each mul/div pass runs a multiply phase over the 24 multiplier bits, then a
// divide phase over the 89 quotient bits (one quotient bit per cycle on the
// shared unit). Query, shift and ignored tempo requests need one pass, jump
// and beat time two, set tempo and set phase three.
// One request is in work at a time; a new one is taken as soon as the
// previous result sits in the output register, even if it is not yet taken.
// When the receiver stalls, a finished request waits until the output
// register frees, and input is held off until then.
// Reset clears the grid start to 0 and sets the tempo to 120 BPM.
// ----------------------------------------------------------------------------
module beat_clock_tracker (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         req_type,
  input  logic [46:0]        now_ms,
  input  logic [23:0]        tempo_value,
  input  logic [16:0]        phase_value,
  input  logic signed [39:0] beat_number,
  input  logic signed [31:0] shift_ms,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [39:0]        beat_count,
  output logic [15:0]        phase_frac,
  output logic signed [48:0] grid_start_ms,
  output logic [23:0]        tempo_now,
  output logic signed [48:0] beat_time_ms,
  output logic               ignored
);
  import bct_pkg::*;

  bct_cmd_t  cmd;
  bct_stat_t stat;

  bct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  bct_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .req_type      (req_type),
    .now_ms        (now_ms),
    .tempo_value   (tempo_value),
    .phase_value   (phase_value),
    .beat_number   (beat_number),
    .shift_ms      (shift_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .beat_count    (beat_count),
    .phase_frac    (phase_frac),
    .grid_start_ms (grid_start_ms),
    .tempo_now     (tempo_now),
    .beat_time_ms  (beat_time_ms),
    .ignored       (ignored)
  );

endmodule

### dv/beat_clock_tracker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// beat_clock_tracker_tb
// Drives random and corner-case requests into the beat clock tracker and
// checks every result beat against a cycle-free model of the beat grid.
// ----------------------------------------------------------------------------
module beat_clock_tracker_tb;
  import bct_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam longint unsigned BEAT_TOP = (64'd1 << 40) - 1;
  localparam longint signed TIME_TOP = (64'sd1 <<< TIME_BITS) - 1;
  localparam longint signed TIME_BOT = -TIME_TOP - 1;

  typedef struct packed {
    logic [39:0] beat;
    logic [15:0] phase;
    logic [48:0] start;
    logic [23:0] tempo;
    logic [48:0] btime;
    logic        ign;
  } grid_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic [46:0] now_ms = '0;
  logic [23:0] tempo_value = '0;
  logic [16:0] phase_value = '0;
  logic signed [39:0] beat_number = '0;
  logic signed [31:0] shift_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [39:0] beat_count;
  logic [15:0] phase_frac;
  logic signed [48:0] grid_start_ms;
  logic [23:0] tempo_now;
  logic signed [48:0] beat_time_ms;
  logic ignored;

  int send_idle_pct;
  int recv_idle_pct;
  int quiet_cycles;

  always #4 clk = ~clk;

  beat_clock_tracker dut (.*);

  class grid_scoreboard;
    longint signed start_time;
    longint unsigned tempo;
    grid_res_t pending[$];
    int mismatches;

    function new();
      start_time = 0;
      tempo = 30720;
      mismatches = 0;
    endfunction

    // floor(a*m/d), saturating when above 64 bits
    function longint unsigned scale(longint unsigned a, longint unsigned m,
                                    longint unsigned d, output longint unsigned r);
      logic [127:0] p;
      logic [127:0] q;
      p = 128'(a) * 128'(m);
      q = p / d;
      r = 64'(p % d);
      return (q[127:64] != 0) ? 64'hffff_ffff_ffff_ffff : q[63:0];
    endfunction

    function longint signed clamp_add(longint signed a, longint signed b);
      logic signed [127:0] s;
      if (a > TIME_TOP) a = TIME_TOP;
      if (a < TIME_BOT) a = TIME_BOT;
      s = 128'(a) + 128'(b);
      if (s > TIME_TOP) return TIME_TOP;
      if (s < TIME_BOT) return TIME_BOT;
      return 64'(s);
    endfunction

    function longint signed back_off(longint signed now, longint unsigned off);
      logic signed [127:0] s;
      s = 128'(now) - $signed({64'd0, off});
      if (s < TIME_BOT) return TIME_BOT;
      return 64'(s);
    endfunction

    function void position(longint signed now, output longint unsigned beat,
                           output longint unsigned phase);
      longint unsigned q, r;
      if (now < start_time) begin
        beat = 1; phase = 0; return;
      end
      q = scale(64'(now - start_time), tempo, 15360000, r);
      if (q >= BEAT_TOP - 1) begin
        beat = BEAT_TOP; phase = 0; return;
      end
      beat = q + 1;
      phase = (r << 16) / 15360000;
    endfunction

    function void note_request(logic [2:0] kind, logic [46:0] now, logic [23:0] tv,
                               logic [16:0] pv, logic signed [39:0] bn,
                               logic signed [31:0] dm);
      longint signed t, bnum, btime;
      longint unsigned beat, phase, off, r, pw;
      grid_res_t res;
      t = longint'({17'd0, now});
      bnum = bn;
      btime = 0;
      res.ign = 1'b0;
      case (kind)
        REQ_SET_TEMPO: begin
          if (tv == 0) res.ign = 1'b1;
          else begin
            position(t, beat, phase);
            tempo = tv;
            off = scale(beat - 1, 15360000, tempo, r);
            start_time = back_off(t, off);
          end
        end
        REQ_SET_PHASE: begin
          pw = (pv > PHASE_ONE) ? 65536 : pv;
          position(t, beat, phase);
          off = scale(((beat - 1) << 16) + pw, 15360000, tempo << 16, r);
          start_time = back_off(t, off);
        end
        REQ_JUMP: begin
          if (bnum < 1) bnum = 1;
          off = scale(64'(bnum - 1), 15360000, tempo, r);
          start_time = back_off(t, off);
        end
        REQ_SHIFT: start_time = clamp_add(start_time, longint'(dm));
        REQ_BEAT_TIME: begin
          if (bnum >= 1) begin
            off = scale(64'(bnum - 1), 15360000, tempo, r);
            btime = (off[63]) ? TIME_TOP : clamp_add(start_time, longint'(off));
          end else begin
            off = scale(64'(1 - bnum), 15360000, tempo, r);
            btime = (off[63]) ? TIME_BOT : clamp_add(start_time, -longint'(off));
          end
        end
        default: ;
      endcase
      position(t, beat, phase);
      res.beat = beat[39:0];
      res.phase = phase[15:0];
      res.start = start_time[48:0];
      res.tempo = tempo[23:0];
      res.btime = btime[48:0];
      pending.push_back(res);
    endfunction

    function void check_result(grid_res_t got);
      grid_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = pending.pop_front();
      if (got !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp beat=%0d ph=%0d st=%0h tp=%0d bt=%0h ig=%0b",
                   exp_r.beat, exp_r.phase, exp_r.start, exp_r.tempo,
                   exp_r.btime, exp_r.ign);
          $display("          got beat=%0d ph=%0d st=%0h tp=%0d bt=%0h ig=%0b",
                   got.beat, got.phase, got.start, got.tempo, got.btime, got.ign);
        end
      end
    endfunction
  endclass

  grid_scoreboard board = new();

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready)
        board.note_request(req_type, now_ms, tempo_value, phase_value, beat_number,
                           shift_ms);
      if (out_valid && out_ready)
        board.check_result({beat_count, phase_frac, grid_start_ms, tempo_now,
                            beat_time_ms, ignored});
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial quiet_cycles = 0;

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid drops only while the sender idles, so one assignment per time step
  task automatic send_request(logic [2:0] kind, logic [46:0] now, logic [23:0] tv,
                              logic [16:0] pv, logic signed [39:0] bn,
                              logic signed [31:0] dm);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    now_ms <= now;
    tempo_value <= tv;
    phase_value <= pv;
    beat_number <= bn;
    shift_ms <= dm;
    do @(posedge clk); while (!in_ready);
  endtask

  // mostly plausible times near the grid, some full-range noise
  task automatic send_random();
    logic [46:0] now;
    logic [23:0] tv;
    logic signed [39:0] bn;
    logic signed [31:0] dm;
    int sel;
    sel = $urandom_range(9);
    now = (sel < 7) ? 47'($urandom_range(2000000)) : 47'({$urandom, $urandom});
    tv = ($urandom_range(9) < 7) ? 24'($urandom_range(8000, 60000)) : 24'($urandom);
    if ($urandom_range(19) == 0) tv = 0;
    bn = ($urandom_range(3) != 0) ? 40'sd0 + $signed(40'($urandom_range(5000))) - 40'sd5
                                  : $signed(40'({$urandom, $urandom}));
    dm = ($urandom_range(1) != 0) ? 32'($signed($urandom_range(20000)) - 10000)
                                  : $signed($urandom);
    send_request(3'($urandom_range(7)), now, tv, 17'($urandom), bn, dm);
  endtask

  initial begin
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    send_request(REQ_QUERY, 47'd0, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_QUERY, 47'd1000, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_TEMPO, 47'd1000, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_TEMPO, 47'd1250, 24'hffffff, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_TEMPO, 47'd1300, 24'd1, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_TEMPO, 47'd5000, 24'd30720, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_PHASE, 47'd5100, 24'd0, 17'h1ffff, 40'sd0, 32'sd0);
    send_request(REQ_SET_PHASE, 47'd5200, 24'd0, 17'd65536, 40'sd0, 32'sd0);
    send_request(REQ_SET_PHASE, 47'd5300, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_JUMP, 47'd6000, 24'd0, 17'd0, -40'sd549755813888, 32'sd0);
    send_request(REQ_JUMP, 47'd6000, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_JUMP, 47'd7000, 24'd0, 17'd0, 40'sd549755813887, 32'sd0);
    send_request(REQ_SHIFT, 47'd7000, 24'd0, 17'd0, 40'sd0, 32'sh7fffffff);
    send_request(REQ_SHIFT, 47'd7000, 24'd0, 17'd0, 40'sd0, -32'sd2147483648);
    send_request(REQ_BEAT_TIME, 47'd7000, 24'd0, 17'd0, 40'sd549755813887, 32'sd0);
    send_request(REQ_BEAT_TIME, 47'd7000, 24'd0, 17'd0, -40'sd549755813888, 32'sd0);
    send_request(REQ_BEAT_TIME, 47'd7000, 24'd0, 17'd0, 40'sd1, 32'sd0);
    send_request(3'd6, {47{1'b1}}, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(3'd7, 47'd10, 24'd0, 17'd0, 40'sd0, 32'sd0);
    // beat overflow: fastest tempo, grid far in the past
    send_request(REQ_SET_TEMPO, 47'd0, 24'hffffff, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_JUMP, 47'd0, 24'd0, 17'd0, 40'sd1, 32'sd0);
    send_request(REQ_QUERY, {47{1'b1}}, 24'd0, 17'd0, 40'sd0, 32'sd0);
    send_request(REQ_SET_TEMPO, {47{1'b1}}, 24'd30720, 17'd0, 40'sd0, 32'sd0);
    for (int phase_i = 0; phase_i < 3; phase_i++) begin
      send_idle_pct = (phase_i == 0) ? 14 : (phase_i == 1) ? 63 : 0;
      recv_idle_pct = (phase_i == 0) ? 63 : (phase_i == 1) ? 14 : 0;
      repeat (400) send_random();
    end
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
src/bct_pkg.sv
src/bct_muldiv.sv
src/bct_datapath.sv
src/bct_ctrl.sv
src/beat_clock_tracker.sv
dv/beat_clock_tracker_tb.sv
